[rtl/rrbt_pkg.sv]
// ----------------------------------------------------------------------------
// rrbt_pkg: shared types and constants for the region rank box table
// Sizes, kind codes and the packet that travels along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rrbt_pkg;

   localparam int MaxBoxes = 16;
   localparam int CoordW   = 16;
   localparam int CornerW  = 3 * CoordW;
   localparam int RankW    = 16;
   localparam int EntW     = 5;
   localparam int CntW     = $clog2(MaxBoxes + 1);

   localparam logic [1:0] KIND_QUERY  = 2'd0;
   localparam logic [1:0] KIND_INSERT = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   typedef struct packed {
      logic               live;
      logic [1:0]         kind;
      logic [CornerW-1:0] lo;
      logic [CornerW-1:0] hi;
      logic [RankW-1:0]   rank;
      logic [RankW-1:0]   best;
      logic               placed;
      logic [CntW-1:0]    count;
   } packet_type;

   function automatic logic [EntW-1:0] sat_count(input logic [CntW-1:0] n);
      logic [CntW+EntW-1:0] ext;
      ext = {{EntW{1'b0}}, n};
      if (ext > (CntW + EntW)'(2 ** EntW - 1)) begin
         return '1;
      end
      return ext[EntW-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/rrbt_cell.sv]
// ----------------------------------------------------------------------------
// rrbt_cell: one table slot of the box chain
// Holds one box, applies the passing packet to it and hands the packet on.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbt_cell
   import rrbt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire packet_type pkt_i,
   output packet_type      pkt_o
);

   logic [CornerW-1:0] lo_ff;
   logic [CornerW-1:0] hi_ff;
   logic [RankW-1:0]   level_ff;
   logic               valid_ff;
   logic               valid_in;
   logic               store;
   packet_type         pkt_ff;
   packet_type         pkt_in;

   always_comb begin
      logic contains;
      logic enclosed;
      logic [CoordW-1:0] p;
      logic [CoordW-1:0] bl;
      logic [CoordW-1:0] bh;
      logic [CoordW-1:0] nh;
      contains = 1'b1;
      enclosed = 1'b1;
      for (int a = 0; a < 3; a++) begin
         p  = pkt_i.lo[a*CoordW +: CoordW];
         nh = pkt_i.hi[a*CoordW +: CoordW];
         bl = lo_ff[a*CoordW +: CoordW];
         bh = hi_ff[a*CoordW +: CoordW];
         if (p < bl || p >= bh) begin
            contains = 1'b0;
         end
         if (bl < p || bh > nh) begin
            enclosed = 1'b0;
         end
      end
      pkt_in   = pkt_i;
      valid_in = valid_ff;
      store    = 1'b0;
      case (pkt_i.kind)
         KIND_QUERY: begin
            if (valid_ff && contains && ($signed(level_ff) > $signed(pkt_i.best))) begin
               pkt_in.best = level_ff;
            end
         end
         KIND_INSERT: begin
            if (valid_ff && enclosed) begin
               valid_in = 1'b0;
            end
            if (!valid_in && !pkt_i.placed) begin
               store         = 1'b1;
               valid_in      = 1'b1;
               pkt_in.placed = 1'b1;
            end
         end
         KIND_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
      if (!pkt_i.live) begin
         valid_in = valid_ff;
         store    = 1'b0;
      end
      pkt_in.count = pkt_i.count + CntW'(valid_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pkt_ff.live <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pkt_ff   <= pkt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store) begin
         lo_ff    <= pkt_i.lo;
         hi_ff    <= pkt_i.hi;
         level_ff <= pkt_i.rank;
      end
   end

   assign pkt_o = pkt_ff;

endmodule

`default_nettype wire

[rtl/region_rank_box_table_core.sv]
// ----------------------------------------------------------------------------
// region_rank_box_table_core: table of ranked 3D boxes with point queries
// A chain of slot cells; each transaction walks the chain one cell a cycle.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tuser kind, tdata box or point
//  rsp     | out | rsp_tvalid/tready    | tdata rank, entries, overflow
//  csr     | in  | csr_wr_en            | csr_wr_data default rank
//
//  one transaction at a time; the result is registered once the packet has
//  stepped through all MaxBoxes slot cells, one slot cell per cycle
//  req_tready stays low until the result transaction completes
//  synchronous reset empties the table and zeroes the default rank
// ----------------------------------------------------------------------------
`default_nettype none

module region_rank_box_table_core
   import rrbt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [1:0]   req_tuser,   // kind
   input  wire logic [111:0] req_tdata,   // x_low, y_low, z_low, x_high, y_high, z_high, box_rank
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [23:0]       rsp_tdata,   // required_rank, entries_used, overflow, zero pad
   input  wire logic         csr_wr_en,
   input  wire logic [15:0]  csr_wr_data
);

   logic [RankW-1:0] default_ff;
   logic             busy_ff;
   logic             rsp_valid_ff;
   logic [23:0]      rsp_data_ff;
   packet_type       pkt [MaxBoxes+1];
   packet_type       tail;
   logic [RankW-1:0] rank_out;
   logic             ovf_out;

   always_comb begin
      pkt[0].live   = req_tvalid && req_tready;
      pkt[0].kind   = req_tuser;
      pkt[0].lo     = req_tdata[CornerW-1:0];
      pkt[0].hi     = req_tdata[2*CornerW-1:CornerW];
      pkt[0].rank   = req_tdata[2*CornerW +: RankW];
      pkt[0].best   = default_ff;
      pkt[0].placed = 1'b0;
      pkt[0].count  = '0;
   end

   for (genvar i = 0; i < MaxBoxes; i++) begin : g_cell
      rrbt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .pkt_i (pkt[i]),
         .pkt_o (pkt[i+1])
      );
   end

   assign tail     = pkt[MaxBoxes];
   assign rank_out = (tail.kind == KIND_QUERY) ? tail.best : '0;
   assign ovf_out  = (tail.kind == KIND_INSERT) && !tail.placed;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_ff   <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            default_ff <= csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            busy_ff <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            busy_ff <= 1'b0;
         end
         if (tail.live) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail.live) begin
         rsp_data_ff <= {2'b00, ovf_out, sat_count(tail.count), rank_out};
      end
   end

   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/rrbt_checker.sv]
// ----------------------------------------------------------------------------
// rrbt_checker: port-level checks for the region rank box table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbt_checker
   import rrbt_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [1:0]   req_tuser,
   input wire logic [111:0] req_tdata,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [23:0]  rsp_tdata,
   input wire logic         csr_wr_en,
   input wire logic [15:0]  csr_wr_data
);

   localparam logic [EntW-1:0] FullCount = sat_count(CntW'(MaxBoxes));

   logic unused_ok;
   assign unused_ok = ^{req_tuser, req_tdata, csr_wr_en, csr_wr_data};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second transaction accepted while busy");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("result without pending request");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[20:16] <= FullCount)
      else $error("entry count above table size");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[21] |-> rsp_tdata[20:16] == FullCount && rsp_tdata[15:0] == 16'd0)
      else $error("overflow with free slots");

endmodule

bind region_rank_box_table_core rrbt_checker u_rrbt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .req_tuser   (req_tuser),
   .req_tdata   (req_tdata),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);

`default_nettype wire

[dv/region_rank_box_table_core_tb.sv]
// ----------------------------------------------------------------------------
// region_rank_box_table_core_tb: self-checking bench for the box rank table
// Drives queries, box inserts, clears and unused kinds through the request
// stream and scores every response against a behavioral table of ranked boxes
// kept here. Runs a directed pass and then random box and point traffic
// under three idle mixes and several default rank settings.
// ----------------------------------------------------------------------------
`default_nettype none

module region_rank_box_table_core_tb;
   import rrbt_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int Latency  = MaxBoxes + 1;
   localparam int RunLimit = 2_000_000;

   typedef struct {
      logic [1:0]         kind;
      logic [CornerW-1:0] lo;
      logic [CornerW-1:0] hi;
      logic [RankW-1:0]   rank;
   } box_req_type;

   typedef struct {
      logic [RankW-1:0] rank;
      logic [EntW-1:0]  used;
      logic             overflow;
   } box_rsp_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser   = '0;
   logic [111:0] req_tdata   = '0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [23:0]  rsp_tdata;
   logic         csr_wr_en   = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   region_rank_box_table_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // behavioral copy of the table
   logic [CornerW-1:0]      slot_lo   [MaxBoxes];
   logic [CornerW-1:0]      slot_hi   [MaxBoxes];
   logic signed [RankW-1:0] slot_rank [MaxBoxes];
   bit                      slot_live [MaxBoxes];
   logic signed [RankW-1:0] base_rank = '0;

   box_req_type req_backlog [$];
   box_rsp_type owed_answers [$];
   box_req_type on_bus;
   box_rsp_type want;

   logic [CornerW-1:0] recent_lo [$];
   logic [CornerW-1:0] recent_hi [$];

   int send_gap_pct   = 24;
   int recv_stall_pct = 62;
   int mismatches     = 0;
   int answers_seen   = 0;
   int overflows_seen = 0;
   int kind_tally [4] = '{default: 0};

   function automatic logic [CoordW-1:0] coord(input logic [CornerW-1:0] v, input int a);
      return v[CoordW*a +: CoordW];
   endfunction

   function automatic logic [CornerW-1:0] corner(input logic [CoordW-1:0] x,
                                                 input logic [CoordW-1:0] y,
                                                 input logic [CoordW-1:0] z);
      return {z, y, x};
   endfunction

   function automatic void queue_item(input box_req_type it);
      req_backlog = {req_backlog, it};
   endfunction

   function automatic box_rsp_type apply_to_table(input box_req_type it);
      box_rsp_type             r;
      logic signed [RankW-1:0] best;
      int                      free_slot;
      int                      used;
      bit                      hit;
      r.rank     = '0;
      r.overflow = 1'b0;
      case (it.kind)
         KIND_QUERY: begin
            best = base_rank;
            for (int i = 0; i < MaxBoxes; i++) begin
               hit = slot_live[i];
               for (int a = 0; a < 3; a++) begin
                  if (coord(it.lo, a) < coord(slot_lo[i], a) ||
                      coord(it.lo, a) >= coord(slot_hi[i], a)) hit = 1'b0;
               end
               if (hit && slot_rank[i] > best) best = slot_rank[i];
            end
            r.rank = best;
         end
         KIND_INSERT: begin
            free_slot = -1;
            for (int i = 0; i < MaxBoxes; i++) begin
               if (slot_live[i]) begin
                  hit = 1'b1;
                  for (int a = 0; a < 3; a++) begin
                     if (coord(slot_lo[i], a) < coord(it.lo, a) ||
                         coord(slot_hi[i], a) > coord(it.hi, a)) hit = 1'b0;
                  end
                  if (hit) slot_live[i] = 1'b0;
               end
               if (!slot_live[i] && free_slot < 0) free_slot = i;
            end
            if (free_slot >= 0) begin
               slot_lo[free_slot]   = it.lo;
               slot_hi[free_slot]   = it.hi;
               slot_rank[free_slot] = it.rank;
               slot_live[free_slot] = 1'b1;
            end else begin
               r.overflow = 1'b1;
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < MaxBoxes; i++) slot_live[i] = 1'b0;
         end
         default: begin
         end
      endcase
      used = 0;
      for (int i = 0; i < MaxBoxes; i++) used += slot_live[i];
      r.used = EntW'((used > (1 << EntW) - 1) ? (1 << EntW) - 1 : used);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            owed_answers = {owed_answers, apply_to_table(on_bus)};
            kind_tally[on_bus.kind]++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
               on_bus = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.kind;
               req_tdata  <= {on_bus.rank, on_bus.hi, on_bus.lo};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_answers.size() == 0) begin
               $error("unexpected response transaction %h", rsp_tdata);
               mismatches++;
            end else begin
               want = owed_answers.pop_front();
               answers_seen++;
               if (rsp_tdata[21]) overflows_seen++;
               if (rsp_tdata[15:0] !== want.rank) begin
                  $error("required_rank: expected %0d, got %0d",
                         $signed(want.rank), $signed(rsp_tdata[15:0]));
                  mismatches++;
               end
               if (rsp_tdata[20:16] !== want.used) begin
                  $error("entries_used: expected %0d, got %0d", want.used, rsp_tdata[20:16]);
                  mismatches++;
               end
               if (rsp_tdata[21] !== want.overflow) begin
                  $error("overflow: expected %0d, got %0d", want.overflow, rsp_tdata[21]);
                  mismatches++;
               end
            end
         end
         rsp_tready <= $urandom_range(99) >= recv_stall_pct;
      end
   end

   function automatic box_req_type box_item(input logic [1:0] kind,
                                            input int x0, input int y0, input int z0,
                                            input int x1, input int y1, input int z1,
                                            input int rank);
      box_req_type it;
      it.kind = kind;
      it.lo   = corner(CoordW'(x0), CoordW'(y0), CoordW'(z0));
      it.hi   = corner(CoordW'(x1), CoordW'(y1), CoordW'(z1));
      it.rank = RankW'(rank);
      return it;
   endfunction

   function automatic logic [CoordW-1:0] pick_coord();
      int m;
      m = $urandom_range(99);
      if (m < 75) return CoordW'($urandom_range(0, 63));
      if (m < 90) return CoordW'(16'hffff - $urandom_range(0, 63));
      return CoordW'($urandom_range(0, 65535));
   endfunction

   function automatic box_req_type make_insert();
      box_req_type      it;
      int               m;
      int               src;
      logic [CoordW-1:0] c;
      it.kind = KIND_INSERT;
      it.rank = RankW'($urandom);
      m = $urandom_range(99);
      if (recent_lo.size() > 0 && m < 25) begin
         src = $urandom_range(recent_lo.size() - 1);
         it.lo = recent_lo[src];
         it.hi = recent_hi[src];
         // grow around an earlier box so it gets swallowed
         if (m >= 8) begin
            for (int a = 0; a < 3; a++) begin
               it.lo[CoordW*a +: CoordW] = CoordW'(coord(it.lo, a) - $urandom_range(0, 3));
               it.hi[CoordW*a +: CoordW] = CoordW'(coord(it.hi, a) + $urandom_range(0, 3));
            end
         end
      end else begin
         for (int a = 0; a < 3; a++) begin
            c = pick_coord();
            it.lo[CoordW*a +: CoordW] = c;
            it.hi[CoordW*a +: CoordW] = (m >= 94) ? CoordW'(c - $urandom_range(0, 2))
                                                  : CoordW'(c + $urandom_range(1, 20));
         end
      end
      recent_lo = {recent_lo, it.lo};
      recent_hi = {recent_hi, it.hi};
      if (recent_lo.size() > 24) begin
         void'(recent_lo.pop_front());
         void'(recent_hi.pop_front());
      end
      return it;
   endfunction

   function automatic box_req_type make_query();
      box_req_type       it;
      int                src;
      logic [CoordW-1:0] l;
      logic [CoordW-1:0] h;
      it.kind = KIND_QUERY;
      it.hi   = CornerW'({$urandom, $urandom});
      it.rank = RankW'($urandom);
      if (recent_lo.size() > 0 && $urandom_range(99) < 70) begin
         src = $urandom_range(recent_lo.size() - 1);
         for (int a = 0; a < 3; a++) begin
            l = coord(recent_lo[src], a);
            h = coord(recent_hi[src], a);
            it.lo[CoordW*a +: CoordW] = (h > l) ? CoordW'(l + $urandom_range(0, h - l)) : l;
         end
      end else begin
         for (int a = 0; a < 3; a++) it.lo[CoordW*a +: CoordW] = pick_coord();
      end
      return it;
   endfunction

   task automatic queue_random_items(input int n);
      box_req_type it;
      int          m;
      for (int k = 0; k < n; k++) begin
         m = $urandom_range(999);
         if (m < 450) begin
            it = make_query();
         end else if (m < 900) begin
            it = make_insert();
         end else begin
            it.kind = (m < 915) ? KIND_CLEAR : (m < 945) ? KIND_UNUSED : KIND_QUERY;
            it.lo   = CornerW'({$urandom, $urandom});
            it.hi   = CornerW'({$urandom, $urandom});
            it.rank = RankW'($urandom);
         end
         queue_item(it);
      end
   endtask

   task automatic settle();
      while (req_backlog.size() > 0 || req_tvalid || owed_answers.size() > 0)
         @(negedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   task automatic write_default(input logic [RankW-1:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      base_rank = v;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed pass, default rank still at reset value
      queue_item(box_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0));
      queue_item(box_item(KIND_INSERT, 0, 0, 0, 'hffff, 'hffff, 'hffff, 'h7fff));
      queue_item(box_item(KIND_QUERY, 0, 0, 0, 0, 0, 0, 0));
      queue_item(box_item(KIND_QUERY, 'hffff, 0, 0, 0, 0, 0, 0));
      // same corners replaces the stored box
      queue_item(box_item(KIND_INSERT, 0, 0, 0, 'hffff, 'hffff, 'hffff, 'h8000));
      queue_item(box_item(KIND_QUERY, 'h10, 'h10, 'h10, 0, 0, 0, 0));
      // inverted box, then an empty box that swallows it
      queue_item(box_item(KIND_INSERT, 'hffff, 'hffff, 'hffff, 0, 0, 0, 'h7fff));
      queue_item(box_item(KIND_INSERT, 0, 0, 0, 0, 0, 0, 1));
      queue_item(box_item(KIND_UNUSED, 'h1234, 'hffff, 'h8001, 'h7ffe, 1, 'hffff,
                          'hffff));
      queue_item(box_item(KIND_CLEAR, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff,
                          'hffff, 'hffff));
      for (int i = 0; i < MaxBoxes; i++)
         queue_item(box_item(KIND_INSERT, 4 * i, 0, 0, 4 * i + 2, 1, 1, i - 8));
      // full table drops the next box
      queue_item(box_item(KIND_INSERT, 100, 100, 100, 101, 101, 101, 'h55));
      queue_item(box_item(KIND_QUERY, 4 * 12 + 1, 0, 0, 0, 0, 0, 0));
      queue_item(box_item(KIND_INSERT, 0, 0, 0, 'hffff, 'hffff, 'hffff, 'h8000));
      settle();

      write_default(16'h8000);
      queue_random_items(90);
      settle();
      queue_random_items(90);
      settle();

      send_gap_pct   = 62;
      recv_stall_pct = 24;
      write_default(16'h7fff);
      queue_random_items(30);
      settle();
      write_default(RankW'($urandom));
      queue_random_items(150);
      settle();

      send_gap_pct   = 0;
      recv_stall_pct = 0;
      write_default(16'h0000);
      queue_random_items(160);
      settle();

      $display("covered %0d responses: %0d queries, %0d inserts (%0d dropped), %0d clears,",
               answers_seen, kind_tally[KIND_QUERY], kind_tally[KIND_INSERT], overflows_seen,
               kind_tally[KIND_CLEAR]);
      $display("%0d unused kinds; default rank at -32768, 32767, a random value and 0",
               kind_tally[KIND_UNUSED]);
      if (mismatches == 0) begin
         $display("region_rank_box_table_core_tb: done, clean");
      end else begin
         $display("region_rank_box_table_core_tb: done, errors");
      end
      $finish;
   end

   initial begin
      #(RunLimit);
      $display("run limit reached");
      $display("region_rank_box_table_core_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

[region_rank_box_table_core.f]
rtl/rrbt_pkg.sv
rtl/rrbt_cell.sv
rtl/region_rank_box_table_core.sv
rtl/rrbt_checker.sv
dv/region_rank_box_table_core_tb.sv
